### rtl/sigaf_pkg.sv
package sigaf_pkg;

  // fixed field widths
  localparam int unsigned ActionW = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned CountW  = 8;

  localparam int unsigned BufferDepthDefault = 128;
  localparam logic [ByteW-1:0] GapTicksReset = 8'd3;

  // apb
  localparam int unsigned PaddrW = 2;
  localparam int unsigned PdataW = 32;

  typedef enum logic [ActionW-1:0] {
    ActByte = 2'd0,
    ActTick = 2'd1,
    ActRead = 2'd2
  } action_e;

  // per-request flags from the frame control to the result register
  typedef struct packed {
    logic frame_done;
    logic byte_dropped;
    logic read_hit;
  } flags_t;

endpackage

### rtl/sigaf_if.sv
interface sigaf_in_if;
  logic                             valid;
  logic                             ready;
  logic [sigaf_pkg::ActionW-1:0]    action;
  logic [sigaf_pkg::ByteW-1:0]      byte_value;
  logic [sigaf_pkg::IndexW-1:0]     read_index;

  modport source (output valid, output action, output byte_value, output read_index,
                  input ready);
  modport sink   (input valid, input action, input byte_value, input read_index,
                  output ready);
endinterface

interface sigaf_out_if;
  logic                             valid;
  logic                             ready;
  logic                             frame_done;
  logic [sigaf_pkg::CountW-1:0]     frame_length;
  logic [sigaf_pkg::ByteW-1:0]      read_data;
  logic                             byte_dropped;

  modport source (output valid, output frame_done, output frame_length,
                  output read_data, output byte_dropped, input ready);
  modport sink   (input valid, input frame_done, input frame_length,
                  input read_data, input byte_dropped, output ready);
endinterface

### rtl/sigaf_cfg.sv
module sigaf_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sigaf_pkg::PaddrW-1:0]    paddr,
  input  logic [sigaf_pkg::PdataW-1:0]    pwdata,
  output logic [sigaf_pkg::PdataW-1:0]    prdata,
  output logic                            pready,
  output logic [sigaf_pkg::ByteW-1:0]     gap_ticks_o
);

  logic [sigaf_pkg::ByteW-1:0] gap_q;
  logic                        wr_en;

  // single register, byte offset within the word is ignored
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[sigaf_pkg::PaddrW-1:0] == '0 || 1'b1)
                  ? {{(sigaf_pkg::PdataW-sigaf_pkg::ByteW){1'b0}}, gap_q}
                  : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= sigaf_pkg::GapTicksReset;
    end else if (wr_en) begin
      gap_q <= pwdata[sigaf_pkg::ByteW-1:0];
    end
  end

  assign gap_ticks_o = gap_q;

endmodule

### rtl/sigaf_store.sv
module sigaf_store #(
  parameter int unsigned BUFFER_DEPTH = sigaf_pkg::BufferDepthDefault,
  localparam int unsigned AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [sigaf_pkg::ByteW-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  output logic [sigaf_pkg::ByteW-1:0] rd_data_o
);

  logic [sigaf_pkg::ByteW-1:0] mem [BUFFER_DEPTH];
  logic [sigaf_pkg::ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/sigaf_ctrl.sv
module sigaf_ctrl #(
  parameter int unsigned BUFFER_DEPTH = sigaf_pkg::BufferDepthDefault,
  localparam int unsigned AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [sigaf_pkg::ActionW-1:0] action_i,
  input  logic [sigaf_pkg::IndexW-1:0]  read_index_i,
  input  logic [sigaf_pkg::ByteW-1:0]   gap_ticks_i,
  output logic                          wr_en_o,
  output logic [AddrW-1:0]              wr_addr_o,
  output logic                          rd_en_o,
  output logic [AddrW-1:0]              rd_addr_o,
  output sigaf_pkg::flags_t             flags_o,
  output logic [sigaf_pkg::CountW-1:0]  length_d_o
);

  localparam logic [sigaf_pkg::CountW-1:0] Depth = sigaf_pkg::CountW'(BUFFER_DEPTH);

  logic [sigaf_pkg::CountW-1:0] count_q, count_d;
  logic [sigaf_pkg::CountW-1:0] length_q, length_d;
  logic [sigaf_pkg::ByteW-1:0]  countdown_q, countdown_d;
  logic [sigaf_pkg::ByteW-1:0]  reload;
  logic [sigaf_pkg::CountW-1:0] idx_ext;
  logic                         full;
  logic                         store_byte;

  assign full    = (count_q == Depth);
  assign reload  = (gap_ticks_i == '0) ? sigaf_pkg::ByteW'(1) : gap_ticks_i;
  assign idx_ext = sigaf_pkg::CountW'(read_index_i);

  always_comb begin
    count_d     = count_q;
    length_d    = length_q;
    countdown_d = countdown_q;
    store_byte  = 1'b0;
    flags_o     = '0;
    case (action_i)
      sigaf_pkg::ActByte: begin
        if (!full) begin
          store_byte = 1'b1;
          count_d    = count_q + sigaf_pkg::CountW'(1);
        end else begin
          flags_o.byte_dropped = 1'b1;
        end
        countdown_d = reload;
      end
      sigaf_pkg::ActTick: begin
        if (count_q != '0) begin
          if (countdown_q == '0) begin
            length_d           = count_q;
            count_d            = '0;
            flags_o.frame_done = 1'b1;
          end else begin
            countdown_d = countdown_q - sigaf_pkg::ByteW'(1);
          end
        end
      end
      sigaf_pkg::ActRead: begin
        flags_o.read_hit = (idx_ext < length_q) && (idx_ext < Depth);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      length_q    <= '0;
      countdown_q <= '0;
    end else if (accept_i) begin
      count_q     <= count_d;
      length_q    <= length_d;
      countdown_q <= countdown_d;
    end
  end

  assign wr_en_o    = accept_i && store_byte;
  assign wr_addr_o  = count_q[AddrW-1:0];
  assign rd_en_o    = accept_i && (action_i == sigaf_pkg::ActRead);
  assign rd_addr_o  = idx_ext[AddrW-1:0];
  assign length_d_o = length_d;

endmodule

### rtl/serial_idle_gap_frame_assembler.sv
// serial idle-gap frame assembler
// in_i carries one request per handshake: a received byte, a time tick or a
// read of a stored byte of the last delivered frame. out_o returns exactly one
// result per request: frame_done, the latched frame_length, read_data and
// byte_dropped.
// bytes are written into a BUFFER_DEPTH-entry store at the running count; each
// byte reloads the idle countdown with gap_ticks (0 acts as 1). a tick that
// finds the countdown at zero with bytes pending closes the frame.
// gap_ticks is written over the apb port at address 0 while the block is idle.
// the user must keep to this, the block does not enforce it. throughput: one
// request per cycle unless out_o stalls. all state updates in the accepting
// cycle; result register and registered store read show it the cycle after.
// when out_o stalls, the result register holds and in_i.ready drops; it rises
// again in the cycle the result is taken, so no bubble is inserted.
// reset clears the frame count, countdown, delivered length, result valid and
// restores gap_ticks to 3; the store contents are not cleared and need no
// clearing pass, since only bytes of a delivered frame can be read back.
module serial_idle_gap_frame_assembler #(
  parameter int unsigned BUFFER_DEPTH = sigaf_pkg::BufferDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sigaf_in_if.sink                      in_i,
  sigaf_out_if.source                   out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sigaf_pkg::PaddrW-1:0]  paddr,
  input  logic [sigaf_pkg::PdataW-1:0]  pwdata,
  output logic [sigaf_pkg::PdataW-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [sigaf_pkg::ByteW-1:0]  gap_ticks;
  logic                         accept;
  logic                         wr_en, rd_en;
  logic [AddrW-1:0]             wr_addr, rd_addr;
  logic [sigaf_pkg::ByteW-1:0]  rd_data;
  sigaf_pkg::flags_t            flags;
  logic [sigaf_pkg::CountW-1:0] length_d;

  // result register
  logic                         out_valid_q;
  sigaf_pkg::flags_t            flags_q;
  logic [sigaf_pkg::CountW-1:0] length_q;

  // accept whenever the result register is free or being emptied this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  sigaf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .gap_ticks_o (gap_ticks)
  );

  sigaf_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .action_i     (in_i.action),
    .read_index_i (in_i.read_index),
    .gap_ticks_i  (gap_ticks),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .flags_o      (flags),
    .length_d_o   (length_d)
  );

  // store read data is captured on the accepting edge, so it lines up with
  // the result register and holds while the output stalls
  sigaf_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_i.byte_value),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q  <= flags;
      length_q <= length_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_done   = flags_q.frame_done;
  assign out_o.frame_length = length_q;
  assign out_o.read_data    = flags_q.read_hit ? rd_data : '0;
  assign out_o.byte_dropped = flags_q.byte_dropped;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // geometry and run control
  localparam int unsigned BufDepth    = sigaf_pkg::BufferDepthDefault;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 5;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned MaxReports  = 10;

  localparam logic [sigaf_pkg::CountW-1:0] BufDepthCnt = sigaf_pkg::CountW'(BufDepth);

  // action code that the block must treat as a no-op
  localparam logic [sigaf_pkg::ActionW-1:0] ActUnused = 2'd3;

  // apb register map
  localparam logic [sigaf_pkg::PaddrW-1:0] GapTicksAddr = '0;

  typedef struct packed {
    logic [sigaf_pkg::ActionW-1:0] action;
    logic [sigaf_pkg::ByteW-1:0]   byte_value;
    logic [sigaf_pkg::IndexW-1:0]  read_index;
  } frame_req_t;

  typedef struct packed {
    logic                         frame_done;
    logic [sigaf_pkg::CountW-1:0] frame_length;
    logic [sigaf_pkg::ByteW-1:0]  read_data;
    logic                         byte_dropped;
  } frame_result_t;

  bit   clk;
  logic rst_n;

  sigaf_in_if  in_if ();
  sigaf_out_if out_if ();

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [sigaf_pkg::PaddrW-1:0] paddr;
  logic [sigaf_pkg::PdataW-1:0] pwdata;
  logic [sigaf_pkg::PdataW-1:0] prdata;
  logic                         pready;

  serial_idle_gap_frame_assembler dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the frame assembler state
  logic [sigaf_pkg::ByteW-1:0]  frame_mem [BufDepth];
  logic [sigaf_pkg::CountW-1:0] open_count;
  logic [sigaf_pkg::CountW-1:0] closed_length;
  logic [sigaf_pkg::CountW-1:0] idle_left;
  logic [sigaf_pkg::ByteW-1:0]  gap_setting;

  // requests waiting for the driver and results waiting for the block
  frame_req_t    pending_reqs[$];
  frame_result_t awaited_results[$];

  int unsigned queued_cnt;
  int unsigned taken_cnt;
  int unsigned result_cnt;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        in_fire;
  logic        hold_arm;
  logic        rx_hold;
  frame_req_t  next_req;

  // clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected result of one request; advances the shadow state
  function automatic frame_result_t predict_frame_result(input frame_req_t req);
    frame_result_t res;
    res = '0;
    case (req.action)
      sigaf_pkg::ActByte: begin
        // a full buffer drops the byte but the idle countdown still reloads
        if (open_count < BufDepthCnt) begin
          frame_mem[open_count[sigaf_pkg::IndexW-1:0]] = req.byte_value;
          open_count = open_count + 1'b1;
        end else begin
          res.byte_dropped = 1'b1;
        end
        idle_left = (gap_setting == '0) ? 8'd1 : gap_setting;
      end
      sigaf_pkg::ActTick: begin
        // ticks without pending bytes change nothing
        if (open_count != '0) begin
          if (idle_left == '0) begin
            closed_length  = open_count;
            open_count     = '0;
            res.frame_done = 1'b1;
          end else begin
            idle_left = idle_left - 1'b1;
          end
        end
      end
      sigaf_pkg::ActRead: begin
        // reads past the delivered frame return zero
        if ({1'b0, req.read_index} < closed_length) res.read_data = frame_mem[req.read_index];
      end
      default: ;
    endcase
    res.frame_length = closed_length;
    return res;
  endfunction

  function automatic void push_req(input logic [sigaf_pkg::ActionW-1:0] action,
                                   input logic [sigaf_pkg::ByteW-1:0] value,
                                   input logic [sigaf_pkg::IndexW-1:0] index);
    frame_req_t req;
    req.action     = action;
    req.byte_value = value;
    req.read_index = index;
    pending_reqs.push_back(req);
    queued_cnt++;
  endfunction

  function automatic void push_ticks(input int unsigned count);
    for (int unsigned k = 0; k < count; k++)
      push_req(sigaf_pkg::ActTick, sigaf_pkg::ByteW'($urandom_range(0, 255)),
               sigaf_pkg::IndexW'($urandom_range(0, 127)));
  endfunction

  // a frame: bytes with short idle runs, usually the closing ticks, then reads back
  function automatic void add_frame_seq(input bit overfill);
    int unsigned eff_gap;
    int unsigned nbytes;
    int unsigned read_lim;
    int unsigned nreads;
    eff_gap = (gap_setting == '0) ? 1 : gap_setting;
    if (overfill) nbytes = $urandom_range(BufDepth + 1, BufDepth + 5);
    else if ($urandom_range(0, 99) < 3) nbytes = $urandom_range(BufDepth - 3, BufDepth + 4);
    else nbytes = $urandom_range(1, 12);
    for (int unsigned k = 0; k < nbytes; k++) begin
      push_req(sigaf_pkg::ActByte, sigaf_pkg::ByteW'($urandom_range(0, 255)),
               sigaf_pkg::IndexW'($urandom_range(0, 127)));
      // short idle runs that stay below the gap
      if ($urandom_range(0, 99) < 25)
        push_ticks($urandom_range(0, (eff_gap - 1 > 3) ? 3 : eff_gap - 1));
    end
    // mostly close the frame, sometimes leave it open so the next one extends it
    if ($urandom_range(0, 99) < 85) push_ticks(eff_gap + 1);
    else push_ticks($urandom_range(0, eff_gap));
    read_lim = (nbytes + 1 > 127) ? 127 : nbytes + 1;
    nreads   = $urandom_range(0, 6);
    for (int unsigned k = 0; k < nreads; k++) begin
      if ($urandom_range(0, 99) < 70)
        push_req(sigaf_pkg::ActRead, sigaf_pkg::ByteW'($urandom_range(0, 255)),
                 sigaf_pkg::IndexW'($urandom_range(0, read_lim)));
      else
        push_req(sigaf_pkg::ActRead, sigaf_pkg::ByteW'($urandom_range(0, 255)),
                 sigaf_pkg::IndexW'($urandom_range(0, 127)));
    end
  endfunction

  // unstructured requests, unused action code included
  function automatic void add_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int unsigned k = 0; k < n; k++)
      push_req(sigaf_pkg::ActionW'($urandom_range(0, 3)),
               sigaf_pkg::ByteW'($urandom_range(0, 255)),
               sigaf_pkg::IndexW'($urandom_range(0, 127)));
  endfunction

  function automatic void fill_random(input int unsigned count, input bit overfill_first);
    int unsigned target;
    target = queued_cnt + count;
    if (overfill_first) add_frame_seq(1'b1);
    while (queued_cnt < target) begin
      if ($urandom_range(0, 99) < 15) add_noise();
      else add_frame_seq(1'b0);
    end
  endfunction

  // apb write with setup and access phases, register written at the access edge
  task automatic write_gap_ticks(input logic [sigaf_pkg::ByteW-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = GapTicksAddr;
    pwdata  = sigaf_pkg::PdataW'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    gap_setting = value;
  endtask

  // every request taken and every result back, then let the block settle
  task automatic wait_drained();
    while (taken_cnt != queued_cnt || awaited_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // request driver: next request once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_fire)) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req          = pending_reqs.pop_front();
        in_if.valid      <= 1'b1;
        in_if.action     <= next_req.action;
        in_if.byte_value <= next_req.byte_value;
        in_if.read_index <= next_req.read_index;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink with random stalls and the long hold-off
  always @(negedge clk) begin
    out_if.ready <= rst_n && !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    rx_hold = 1'b0;
    wait (hold_arm);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold = 1'b0;
  end

  // monitor: check results against the oldest expectation, predict on accept
  // fields are shown as done/len/data/drop
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        if (mismatch_cnt < MaxReports)
          $display("result %0d with nothing outstanding: got %0b/%0d/%02h/%0b",
                   result_cnt, out_if.frame_done, out_if.frame_length,
                   out_if.read_data, out_if.byte_dropped);
        mismatch_cnt++;
      end else begin
        want = awaited_results.pop_front();
        if (out_if.frame_done !== want.frame_done ||
            out_if.frame_length !== want.frame_length ||
            out_if.read_data !== want.read_data ||
            out_if.byte_dropped !== want.byte_dropped) begin
          if (mismatch_cnt < MaxReports)
            $display("result %0d mismatch: expected %0b/%0d/%02h/%0b got %0b/%0d/%02h/%0b",
                     result_cnt, want.frame_done, want.frame_length, want.read_data,
                     want.byte_dropped, out_if.frame_done, out_if.frame_length,
                     out_if.read_data, out_if.byte_dropped);
          mismatch_cnt++;
        end
      end
      result_cnt++;
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      awaited_results.push_back(predict_frame_result({in_if.action, in_if.byte_value,
                                                      in_if.read_index}));
      taken_cnt++;
    end
    in_fire <= rst_n && in_if.valid && in_if.ready;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // known values on every input while reset is held
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = sigaf_pkg::ActByte;
    in_if.byte_value = '0;
    in_if.read_index = '0;
    out_if.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_fire          = 1'b0;
    hold_arm         = 1'b0;
    queued_cnt       = 0;
    taken_cnt        = 0;
    result_cnt       = 0;
    mismatch_cnt     = 0;
    cycle_cnt        = 0;
    send_idle_pct    = 32;
    recv_idle_pct    = 70;
    for (int unsigned k = 0; k < BufDepth; k++) frame_mem[k] = '0;
    open_count    = '0;
    closed_length = '0;
    idle_left     = '0;
    gap_setting   = sigaf_pkg::GapTicksReset;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset gap of 3, empty reads, idle tick, unused code,
    // a three-byte frame closed by the fourth tick, reads in and past the
    // frame, then a new frame overwriting position 0
    push_req(sigaf_pkg::ActRead, 8'h00, 7'd127);
    push_req(sigaf_pkg::ActTick, 8'h00, 7'd0);
    push_req(ActUnused, 8'hFF, 7'd127);
    push_req(sigaf_pkg::ActByte, 8'h00, 7'd0);
    push_req(sigaf_pkg::ActByte, 8'hFF, 7'd127);
    push_req(sigaf_pkg::ActByte, 8'hA5, 7'd0);
    push_ticks(4);
    push_req(sigaf_pkg::ActRead, 8'h00, 7'd0);
    push_req(sigaf_pkg::ActRead, 8'h00, 7'd1);
    push_req(sigaf_pkg::ActRead, 8'h00, 7'd2);
    push_req(sigaf_pkg::ActRead, 8'h00, 7'd3);
    push_req(sigaf_pkg::ActRead, 8'h00, 7'd127);
    push_req(sigaf_pkg::ActByte, 8'h5A, 7'd0);
    push_req(sigaf_pkg::ActRead, 8'h00, 7'd0);
    push_ticks(4);
    push_req(sigaf_pkg::ActRead, 8'h00, 7'd1);
    wait_drained();

    // gap 0 acts as 1; opens with a frame that overruns the buffer
    write_gap_ticks(8'd0);
    fill_random(400, 1'b1);
    wait_drained();

    // gap 1, idling the other way round
    send_idle_pct = 70;
    recv_idle_pct = 32;
    write_gap_ticks(8'd1);
    fill_random(400, 1'b0);
    wait_drained();

    // widest gap, no idling; sender pauses halfway until all results are back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gap_ticks(8'd255);
    fill_random(250, 1'b0);
    wait_drained();
    fill_random(250, 1'b0);
    wait_drained();

    // random gap with the long receiver hold-off
    write_gap_ticks(sigaf_pkg::ByteW'($urandom_range(2, 16)));
    fill_random(300, 1'b1);
    hold_arm = 1'b1;
    wait_drained();

    if (mismatch_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### serial_idle_gap_frame_assembler.f
rtl/sigaf_pkg.sv
rtl/sigaf_if.sv
rtl/sigaf_cfg.sv
rtl/sigaf_store.sv
rtl/sigaf_ctrl.sv
rtl/serial_idle_gap_frame_assembler.sv
test/testbench.sv
